/* rtl/spi_register_access_sequencer_defines.svh */
// assertion macros for the spi register access sequencer
// expects signals clk and rst_n in the scope where a macro is used
`ifndef SPI_REGISTER_ACCESS_SEQUENCER_DEFINES_SVH
`define SPI_REGISTER_ACCESS_SEQUENCER_DEFINES_SVH

// same-cycle implication
`define SRAS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SRAS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/sras_pkg.sv */
// types and codes shared by the spi register access sequencer
// no dependencies
`default_nettype none

package sras_pkg;

    localparam logic [1:0] MODE_START = 2'd0;
    localparam logic [1:0] MODE_TXBL  = 2'd1;
    localparam logic [1:0] MODE_TXC   = 2'd2;
    localparam logic [1:0] MODE_RXDV  = 2'd3;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_MASKED = 2'd1;
    localparam logic [1:0] ST_WRONG  = 2'd2;
    localparam logic [1:0] ST_REJECT = 2'd3;

    typedef struct packed {
        logic [1:0]  mode;
        logic [5:0]  reg_address;
        logic        is_read;
        logic [2:0]  byte_count;
        logic [31:0] write_word;
        logic [7:0]  rx_byte;
    } item_t;

    typedef struct packed {
        logic        tx_valid;
        logic [7:0]  tx_byte;
        logic        chip_select_n;
        logic        busy_res;
        logic        done_res;
        logic [31:0] read_word;
        logic [1:0]  status;
    } result_t;

endpackage

`default_nettype wire

/* rtl/sras_core.sv */
// transaction state and per-word step logic of the spi register access sequencer
// depends on sras_pkg and spi_register_access_sequencer_defines.svh
`default_nettype none
`include "spi_register_access_sequencer_defines.svh"

module sras_core
    import sras_pkg::*;
#(
    parameter int MAX_BYTES = 4
)
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    step,
    input  wire item_t   item,
    output result_t      res
);

    localparam int CNT_W = $clog2(MAX_BYTES + 1);

    localparam logic [1:0] PH_IDLE        = 2'd0;
    localparam logic [1:0] PH_COMMAND     = 2'd1;
    localparam logic [1:0] PH_TRANSMIT    = 2'd2;
    localparam logic [1:0] PH_WAIT_FINISH = 2'd3;

    localparam logic [2:0] EN_TXBL = 3'b001;
    localparam logic [2:0] EN_TXC  = 3'b010;
    localparam logic [2:0] EN_RXDV = 3'b100;

    logic [1:0]       phase_reg, phase_next;
    logic             busy_reg, busy_next;
    logic             read_mode_reg, read_mode_next;
    logic [5:0]       address_reg, address_next;
    logic [31:0]      write_word_reg, write_word_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] sent_reg, sent_next;
    logic [CNT_W-1:0] recv_reg, recv_next;
    logic [31:0]      accum_reg, accum_next;
    logic [2:0]       enables_reg, enables_next;
    logic             select_reg, select_next;

    logic [7:0]       cmd_byte;
    logic [CNT_W-1:0] sent_inc;
    logic [CNT_W-1:0] byte_idx;
    logic [31:0]      write_shifted;
    logic [2:0]       recv_low;
    logic [31:0]      rx_shifted;

    always_comb
    begin
        cmd_byte      = {read_mode_reg, address_reg, 1'b0};
        sent_inc      = sent_reg + CNT_W'(1);
        byte_idx      = count_reg - sent_inc;
        write_shifted = write_word_reg >> (8 * 32'(byte_idx));
        recv_low      = 3'(recv_reg);
        rx_shifted    = 32'(item.rx_byte) << (8 * 32'(recv_low));
    end

    always_comb
    begin
        phase_next      = phase_reg;
        busy_next       = busy_reg;
        read_mode_next  = read_mode_reg;
        address_next    = address_reg;
        write_word_next = write_word_reg;
        count_next      = count_reg;
        sent_next       = sent_reg;
        recv_next       = recv_reg;
        accum_next      = accum_reg;
        enables_next    = enables_reg;
        select_next     = select_reg;
        res.tx_valid    = 1'b0;
        res.tx_byte     = 8'd0;
        res.done_res    = 1'b0;
        res.status      = ST_OK;

        unique case (item.mode)
            MODE_START:
            begin
                if (busy_reg || item.byte_count == 3'd0 || int'(item.byte_count) > MAX_BYTES)
                begin
                    res.status = ST_REJECT;
                end
                else
                begin
                    busy_next       = 1'b1;
                    address_next    = item.reg_address;
                    read_mode_next  = item.is_read;
                    count_next      = CNT_W'(item.byte_count);
                    write_word_next = item.write_word;
                    sent_next       = '0;
                    recv_next       = CNT_W'(item.byte_count);
                    accum_next      = '0;
                    phase_next      = PH_COMMAND;
                    select_next     = 1'b0;
                    enables_next    = EN_TXBL | (item.is_read ? EN_RXDV : 3'b000);
                end
            end
            MODE_TXBL:
            begin
                if ((enables_reg & EN_TXBL) == 3'b000)
                begin
                    res.status = ST_MASKED;
                end
                else if (phase_reg == PH_COMMAND)
                begin
                    phase_next   = PH_TRANSMIT;
                    res.tx_valid = 1'b1;
                    res.tx_byte  = cmd_byte;
                end
                else if (phase_reg == PH_TRANSMIT)
                begin
                    sent_next = sent_inc;
                    if (read_mode_reg)
                    begin
                        if (sent_inc == count_reg)
                        begin
                            enables_next = enables_reg & ~EN_TXBL;
                            res.tx_valid = 1'b1;
                        end
                        else if (sent_inc < count_reg)
                        begin
                            res.tx_valid = 1'b1;
                            res.tx_byte  = cmd_byte;
                        end
                    end
                    else
                    begin
                        if (sent_inc == count_reg)
                        begin
                            enables_next = (enables_reg & ~EN_TXBL) | EN_TXC;
                            phase_next   = PH_WAIT_FINISH;
                        end
                        if (sent_inc <= count_reg)
                        begin
                            res.tx_valid = 1'b1;
                            res.tx_byte  = write_shifted[7:0];
                        end
                    end
                end
                else
                begin
                    res.status = ST_WRONG;
                end
            end
            MODE_TXC:
            begin
                if ((enables_reg & EN_TXC) == 3'b000)
                begin
                    res.status = ST_MASKED;
                end
                else if (phase_reg == PH_WAIT_FINISH)
                begin
                    enables_next = enables_reg & ~EN_TXC;
                    busy_next    = 1'b0;
                    select_next  = 1'b1;
                    phase_next   = PH_IDLE;
                    res.done_res = 1'b1;
                end
                else
                begin
                    res.status = ST_WRONG;
                end
            end
            MODE_RXDV:
            begin
                if ((enables_reg & EN_RXDV) == 3'b000)
                begin
                    res.status = ST_MASKED;
                end
                else if (phase_reg == PH_TRANSMIT)
                begin
                    if (recv_reg == count_reg)
                    begin
                        recv_next = recv_reg - CNT_W'(1);
                    end
                    else
                    begin
                        accum_next = accum_reg | rx_shifted;
                        if (recv_reg == '0)
                        begin
                            enables_next = enables_reg & ~(EN_RXDV | EN_TXBL);
                            busy_next    = 1'b0;
                            select_next  = 1'b1;
                            phase_next   = PH_IDLE;
                            res.done_res = 1'b1;
                        end
                        else
                        begin
                            recv_next = recv_reg - CNT_W'(1);
                        end
                    end
                end
                else
                begin
                    res.status = ST_WRONG;
                end
            end
        endcase

        res.chip_select_n = select_next;
        res.busy_res      = busy_next;
        res.read_word     = accum_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            busy_reg       <= 1'b0;
            read_mode_reg  <= 1'b0;
            address_reg    <= '0;
            write_word_reg <= '0;
            count_reg      <= '0;
            sent_reg       <= '0;
            recv_reg       <= '0;
            accum_reg      <= '0;
            enables_reg    <= '0;
            select_reg     <= 1'b1;
        end
        else if (step)
        begin
            phase_reg      <= phase_next;
            busy_reg       <= busy_next;
            read_mode_reg  <= read_mode_next;
            address_reg    <= address_next;
            write_word_reg <= write_word_next;
            count_reg      <= count_next;
            sent_reg       <= sent_next;
            recv_reg       <= recv_next;
            accum_reg      <= accum_next;
            enables_reg    <= enables_next;
            select_reg     <= select_next;
        end
    end

    `SRAS_ASSERT_NOW(a_cs_tracks_busy, 1'b1, select_reg == !busy_reg, "chip select out of step with busy")
    `SRAS_ASSERT_NOW(a_idle_no_enables, !busy_reg, enables_reg == 3'b000 && phase_reg == PH_IDLE, "idle with live enables or phase")
    `SRAS_ASSERT_NOW(a_sent_in_range, busy_reg, sent_reg <= count_reg, "sent count past byte count")
    `SRAS_ASSERT_NEXT(a_done_ends, step && res.done_res, !busy_reg && select_reg, "done without release")

endmodule

`default_nettype wire

/* rtl/spi_register_access_sequencer.sv */
// spi register access sequencer: one event word in, one result word out.
// Input: in_valid/in_ready with mode, reg_address, is_read, byte_count,
//   write_word and rx_byte. A start loads a transaction and drops chip select;
//   tx buffer ready, tx complete and rx data valid events walk it through the
//   command byte, the data bytes and the receive assembly.
// Output: out_valid/out_ready with tx_valid, tx_byte, chip_select_n, busy_res,
//   done_res, read_word and status, one result for every event.
// Path: an accepted event waits in the input register, then the step logic
//   loads the result register, which raises out_valid; a full result register
//   that is not taken holds the event back in the input register.
// Throughput: one event per cycle while the result is taken; the transaction
//   state updates in the same edge that loads the result register.
// Stall: while out_ready is low the result holds and one more event may sit
//   in the input register; in_ready then drops until the result is taken.
// Reset: asynchronous, active low; core chip select high, not busy, all events
//   masked, counters, read word and result cleared, both registers empty.
// depends on sras_pkg and sras_core
`default_nettype none

module spi_register_access_sequencer
    import sras_pkg::*;
#(
    parameter int MAX_BYTES = 4
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  mode,
    input  wire logic [5:0]  reg_address,
    input  wire logic        is_read,
    input  wire logic [2:0]  byte_count,
    input  wire logic [31:0] write_word,
    input  wire logic [7:0]  rx_byte,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             tx_valid,
    output logic [7:0]       tx_byte,
    output logic             chip_select_n,
    output logic             busy_res,
    output logic             done_res,
    output logic [31:0]      read_word,
    output logic [1:0]       status
);

    item_t   item_reg;
    result_t result_reg;
    result_t step_res;
    logic    in_full_reg, in_full_next;
    logic    out_full_reg, out_full_next;
    logic    advance;
    logic    take_in;

    sras_core #(
        .MAX_BYTES (MAX_BYTES)
    ) u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (advance),
        .item  (item_reg),
        .res   (step_res)
    );

    always_comb
    begin
        advance       = in_full_reg && (!out_full_reg || out_ready);
        in_ready      = !in_full_reg || advance;
        take_in       = in_valid && in_ready;
        in_full_next  = take_in || (in_full_reg && !advance);
        out_full_next = advance || (out_full_reg && !out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg  <= 1'b0;
            out_full_reg <= 1'b0;
        end
        else
        begin
            in_full_reg  <= in_full_next;
            out_full_reg <= out_full_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_reg   <= '0;
            result_reg <= '0;
        end
        else
        begin
            if (take_in)
            begin
                item_reg <= '{mode: mode, reg_address: reg_address, is_read: is_read,
                              byte_count: byte_count, write_word: write_word,
                              rx_byte: rx_byte};
            end
            if (advance)
            begin
                result_reg <= step_res;
            end
        end
    end

    assign out_valid     = out_full_reg;
    assign tx_valid      = result_reg.tx_valid;
    assign tx_byte       = result_reg.tx_byte;
    assign chip_select_n = result_reg.chip_select_n;
    assign busy_res      = result_reg.busy_res;
    assign done_res      = result_reg.done_res;
    assign read_word     = result_reg.read_word;
    assign status        = result_reg.status;

endmodule

`default_nettype wire
